// File: rtl/core/fpa_pkg.sv
// Shared widths, opcodes and pipeline stage records for the Q24.8 fixed-point ALU.
package fpa_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 8;

  // Rounding numerator 2*|a|*2^F + |b| and its quotient
  localparam int NUM_W = DATA_WIDTH + FRAC_BITS + 1;
  // Doubled divisor 2*|b| and the partial remainder below it
  localparam int DEN_W = DATA_WIDTH + 1;
  localparam int REM_W = DATA_WIDTH + 1;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } alu_op_t;

  // One item in flight through the divider stages
  typedef struct packed {
    alu_op_t                       action;
    logic signed [DATA_WIDTH-1:0]  res;
    logic                          cmp;
    logic                          dz;
    logic                          neg;
    logic [DEN_W-1:0]              den;
    logic [REM_W-1:0]              rem;
    logic [NUM_W-1:0]              nq;
  } div_stage_t;

  // Front stage: the stage record plus the full product
  typedef struct packed {
    div_stage_t                      st;
    logic signed [2*DATA_WIDTH-1:0]  prod;
  } front_t;

endpackage

// File: rtl/core/fixed_point_q24_8_alu_top.sv
// Top level of the pipelined Q24.8 fixed-point ALU.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_ready  | action, operand_a, operand_b
//   output  | out_valid / out_ready| result_value, compare_true, divide_by_zero
//
// Each Q24.8 item passes through one front stage (decode, multiplier,
// divider set-up), one restoring-divider stage per quotient bit, and the
// output register. One item enters per cycle while in_ready is high; all
// operations share the same path so results leave in order. Reset clears
// the valid bits only. A stalled output holds its stage; bubbles further
// up still close, so items keep entering until every stage is full.
module fixed_point_q24_8_alu_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [3:0]                          action,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_a,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fpa_pkg::DATA_WIDTH-1:0] result_value,
  output logic                                compare_true,
  output logic                                divide_by_zero
);
  import fpa_pkg::*;

  localparam int LAST = NUM_W - 1;

  function automatic div_stage_t div_step(input div_stage_t x);
    div_stage_t           y;
    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic                 qbit;
    y     = x;
    trial = {x.rem, x.nq[NUM_W-1]};
    diff  = trial - {1'b0, x.den};
    qbit  = ~diff[REM_W];
    y.rem = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    y.nq  = {x.nq[NUM_W-2:0], qbit};
    return y;
  endfunction

  front_t                   s0;
  front_t                   s0_next;
  logic                     s0_vld;
  logic                     s0_rdy;
  div_stage_t               s0_fold;
  div_stage_t               pipe [NUM_W];
  logic [NUM_W-1:0]         pvld;
  logic [NUM_W-1:0]         prdy;
  logic                     out_rdy;

  logic signed [DATA_WIDTH-1:0] res_final;
  logic [DATA_WIDTH-1:0]        qword;

  // Front stage decode
  always_comb begin
    logic                  lt;
    logic                  eq;
    logic [DATA_WIDTH-1:0] na;
    logic [DATA_WIDTH-1:0] nb;
    lt = operand_a < operand_b;
    eq = operand_a == operand_b;
    na = operand_a[DATA_WIDTH-1] ? DATA_WIDTH'(-operand_a) : operand_a;
    nb = operand_b[DATA_WIDTH-1] ? DATA_WIDTH'(-operand_b) : operand_b;

    s0_next.st.action = alu_op_t'(action);
    s0_next.st.res    = '0;
    s0_next.st.cmp    = 1'b0;
    s0_next.st.dz     = (alu_op_t'(action) == OP_DIV) && (operand_b == '0);
    s0_next.st.neg    = operand_a[DATA_WIDTH-1] ^ operand_b[DATA_WIDTH-1];
    s0_next.st.den    = {nb, 1'b0};
    s0_next.st.rem    = '0;
    s0_next.st.nq     = (NUM_W'({na, 1'b0}) << FRAC_BITS) + NUM_W'(nb);
    s0_next.prod      = (2*DATA_WIDTH)'(operand_a) * (2*DATA_WIDTH)'(operand_b);

    unique case (alu_op_t'(action)) inside
      OP_ADD:           s0_next.st.res = operand_a + operand_b;
      OP_SUB:           s0_next.st.res = operand_a - operand_b;
      OP_MUL, OP_DIV:   s0_next.st.res = '0;
      OP_LT:            s0_next.st.cmp = lt;
      OP_GT:            s0_next.st.cmp = ~lt & ~eq;
      OP_LE:            s0_next.st.cmp = lt | eq;
      OP_GE:            s0_next.st.cmp = ~lt;
      OP_EQ:            s0_next.st.cmp = eq;
      OP_NE:            s0_next.st.cmp = ~eq;
      OP_MIN:           s0_next.st.res = lt ? operand_a : operand_b;
      OP_MAX:           s0_next.st.res = (~lt & ~eq) ? operand_a : operand_b;
      OP_INC:           s0_next.st.res = operand_a + DATA_WIDTH'(1);
      OP_DEC:           s0_next.st.res = operand_a - DATA_WIDTH'(1);
      OP_FROM_INT:      s0_next.st.res = operand_a << FRAC_BITS;
      OP_TO_INT:        s0_next.st.res = operand_a >>> FRAC_BITS;
      default:          s0_next.st.res = '0;
    endcase
  end

  // Fold the shifted product into the record as it enters the divider
  always_comb begin
    s0_fold = s0.st;
    if (s0.st.action == OP_MUL) begin
      s0_fold.res = s0.prod[FRAC_BITS +: DATA_WIDTH];
    end
  end

  // A stage may advance when a bubble sits at or beyond it, or the output frees up
  always_comb begin
    logic [NUM_W-1:0] lowmask;
    out_rdy = ~out_valid | out_ready;
    for (int k = 0; k < NUM_W; k++) begin
      lowmask = (NUM_W'(1) << k) - NUM_W'(1);
      prdy[k] = out_rdy | ~(&(pvld | lowmask));
    end
    s0_rdy   = ~s0_vld | prdy[0];
    in_ready = s0_rdy;
  end

  // Output select: signed, rounded quotient (zero on divide by zero) or the value carried along
  always_comb begin
    qword     = pipe[LAST].nq[DATA_WIDTH-1:0];
    res_final = pipe[LAST].res;
    if (pipe[LAST].action == OP_DIV) begin
      if (pipe[LAST].dz) begin
        res_final = '0;
      end else if (pipe[LAST].neg) begin
        res_final = DATA_WIDTH'(-qword);
      end else begin
        res_final = qword;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld    <= 1'b0;
      pvld      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s0_rdy) begin
        s0_vld <= in_valid;
      end
      if (prdy[0]) begin
        pvld[0] <= s0_vld;
      end
      for (int k = 1; k < NUM_W; k++) begin
        if (prdy[k]) begin
          pvld[k] <= pvld[k-1];
        end
      end
      if (out_rdy) begin
        out_valid <= pvld[LAST];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_valid) begin
      s0 <= s0_next;
    end
    if (prdy[0] && s0_vld) begin
      pipe[0] <= div_step(s0_fold);
    end
    for (int k = 1; k < NUM_W; k++) begin
      if (prdy[k] && pvld[k-1]) begin
        pipe[k] <= div_step(pipe[k-1]);
      end
    end
    // Hold the result until its transfer completes
    if (out_rdy && pvld[LAST]) begin
      result_value   <= res_final;
      compare_true   <= pipe[LAST].cmp;
      divide_by_zero <= pipe[LAST].dz;
    end
  end

endmodule

// File: rtl/core/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [3:0]                           action,
  input logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_a,
  input logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_b,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [fpa_pkg::DATA_WIDTH-1:0] result_value,
  input logic                                 compare_true,
  input logic                                 divide_by_zero
);
  import fpa_pkg::*;

  // No result may appear in the cycle after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(compare_true) && $stable(divide_by_zero))
    else $error("stalled result changed");

  // Input back-pressure only while a result waits at the output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output");

  // Divide by zero gives a zero value and no compare outcome
  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_value == '0 && !compare_true)
    else $error("divide by zero with non-zero result");

  // Compares carry a zero value
  a_cmp_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result_value == '0)
    else $error("compare outcome with non-zero value");

endmodule

bind fixed_point_q24_8_alu_top fpa_checker u_fpa_checker (.*);
